// ===== hw/rtl/smm_pkg.sv =====
// Shared types and constants for the source matching mailbox.
package smm_pkg;

  localparam int PROC_W = 4;
  localparam int SRC_W  = 4;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    STS_STORED    = 2'd0,
    STS_DELIVERED = 2'd1,
    STS_NO_MATCH  = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    store;
    logic    scan;
    logic    hit;
    logic    shift;
    logic    dec;
    logic    push;
    logic    set_status;
    status_t code;
  } smm_cmd_t;

  typedef struct packed {
    logic is_recv;
    logic full;
    logic hit;
    logic drained;
    logic out_free;
  } smm_sts_t;

endpackage

// ===== hw/rtl/smm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module smm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/smm_datapath.sv =====
// Mailbox datapath: item registers, per-mailbox counts, slot RAM, scan and shift pointers.
module smm_datapath
  import smm_pkg::*;
#(
  parameter int SLOTS = 8,
  parameter int PROCS = 16,
  parameter int PBITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  smm_cmd_t    cmd,
  output smm_sts_t    sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int MBOX   = (PROCS < 16) ? PROCS : 16;
  localparam int MB_W   = $clog2(MBOX);
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int PW     = (PBITS < WORD_W) ? PBITS : WORD_W;
  localparam int ENT_W  = SRC_W + PW;
  localparam int ADDR_W = MB_W + IDX_W;
  localparam int DEPTH  = MBOX * (2 ** IDX_W);

  logic              op_r;
  logic [PROC_W-1:0] proc_r;
  logic [SRC_W-1:0]  src_r;
  logic              any_r;
  logic [PW-1:0]     pay_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_idx_r;
  status_t           res_status_r;
  logic [SRC_W-1:0]  res_src_r;
  logic [WORD_W-1:0] res_pay_r;
  logic [CNT_W-1:0]  mbox_cnt_r [MBOX];
  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  logic              in_range;
  logic [MB_W-1:0]   mbox_sel;
  logic [CNT_W-1:0]  cur_cnt;
  logic              issue;
  logic [ENT_W-1:0]  rdata;
  logic [SRC_W-1:0]  rd_src;
  logic [PW-1:0]     rd_pay;
  logic              match;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;

  assign in_range = 32'(proc_r) < PROCS;
  assign mbox_sel = proc_r[MB_W-1:0];
  assign cur_cnt  = in_range ? mbox_cnt_r[mbox_sel] : '0;
  assign issue    = (cmd.scan | cmd.shift) & (rd_idx_r < cur_cnt);
  assign rd_src   = rdata[ENT_W-1:PW];
  assign rd_pay   = rdata[PW-1:0];
  assign match    = pend_r & (any_r | (rd_src == src_r));

  assign raddr = {mbox_sel, rd_idx_r[IDX_W-1:0]};
  assign we    = cmd.store | (cmd.shift & pend_r);
  assign waddr = cmd.store ? {mbox_sel, cur_cnt[IDX_W-1:0]}
                           : {mbox_sel, pend_idx_r - IDX_W'(1)};
  assign wdata = cmd.store ? {src_r, pay_r} : rdata;

  assign sts.is_recv  = op_r;
  assign sts.full     = !in_range || (cur_cnt == CNT_W'(SLOTS));
  assign sts.hit      = match;
  assign sts.drained  = !pend_r && (rd_idx_r >= cur_cnt);
  assign sts.out_free = !out_tvalid_r || out_tready;

  smm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < MBOX; i++) begin
        mbox_cnt_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
      end else if (cmd.hit) begin
        rd_idx_r <= CNT_W'(pend_idx_r) + CNT_W'(1);
        pend_r   <= 1'b0;
      end else if (cmd.scan || cmd.shift) begin
        pend_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
      if (cmd.store) begin
        mbox_cnt_r[mbox_sel] <= cur_cnt + CNT_W'(1);
      end else if (cmd.dec) begin
        mbox_cnt_r[mbox_sel] <= cur_cnt - CNT_W'(1);
      end
      if (cmd.push) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      proc_r    <= in_tdata[3:0];
      src_r     <= in_tdata[7:4];
      any_r     <= in_tdata[8];
      pay_r     <= in_tdata[9 +: PW];
      res_src_r <= '0;
      res_pay_r <= '0;
    end
    if (issue) begin
      pend_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (cmd.hit) begin
      res_src_r    <= rd_src;
      res_pay_r    <= WORD_W'(rd_pay);
      res_status_r <= STS_DELIVERED;
    end else if (cmd.set_status) begin
      res_status_r <= cmd.code;
    end
    if (cmd.push) begin
      out_tdata_r <= {4'b0, res_pay_r, res_src_r};
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hw/rtl/smm_ctrl.sv =====
// Mailbox controller: sequences store, scan, shift and result hand-off.
module smm_ctrl
  import smm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  smm_sts_t sts,
  output smm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.code  = STS_STORED;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (sts.is_recv) begin
          cmd.scan  = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.set_status = 1'b1;
          if (sts.full) begin
            cmd.code = STS_FULL;
          end else begin
            cmd.store = 1'b1;
            cmd.code  = STS_STORED;
          end
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_SHIFT;
        end else if (sts.drained) begin
          cmd.set_status = 1'b1;
          cmd.code       = STS_NO_MATCH;
          state_nxt      = S_FIN;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.drained) begin
          cmd.dec   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/source_matching_mailbox_top.sv =====
// Top level of the source matching mailbox.
// Each process owns SLOTS_PER_MAILBOX message slots kept in age order in one slot RAM;
// a send appends behind the current count, a receive scans from the oldest entry for
// the first matching source and then moves the younger entries up one place. One word
// is handled at a time: a send goes from S_SEND to S_FIN; a receive goes from S_SEND through
// S_SCAN, which reads entries until a match or the end, and after a match through S_SHIFT,
// which moves the younger entries up, to S_FIN. The slot RAM has one read and one write port;
// a result still stalled at the output holds the next result back in S_FIN.
// A finished result waits in the output register while the next word is taken in.
// No clearing pass is needed after reset; the per-mailbox counts start at zero.
module source_matching_mailbox_top
  import smm_pkg::*;
#(
  parameter int SLOTS_PER_MAILBOX = 8,
  parameter int PROCESS_COUNT     = 16,
  parameter int PAYLOAD_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // process_id[3:0], source_id[7:4], match_any[8],
                                  // message_payload[40:9], zero pad[47:41]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // delivered_source[3:0], delivered_payload[35:4],
                                  // zero pad[39:36]
  output logic [1:0]  out_tuser   // status
);

  smm_cmd_t cmd;
  smm_sts_t sts;

  smm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smm_datapath #(
    .SLOTS(SLOTS_PER_MAILBOX),
    .PROCS(PROCESS_COUNT),
    .PBITS(PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

// ===== hw/rtl/smm_checker.sv =====
// Port-level assertions for the mailbox top level, bound to it.
module smm_checker
  import smm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_zero_unless_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != STS_DELIVERED) |-> (out_tdata == '0))
    else $error("result data nonzero on a non-delivered status");

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind source_matching_mailbox_top smm_checker u_smm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the source matching mailbox: directed and random words.
module tb_top;
  import smm_pkg::*;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;
  localparam int SLOTS = 8;
  localparam int PROCS = 16;
  localparam int RANDOM_WORDS = 450;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    status_t     sts;
    logic [3:0]  src;
    logic [31:0] pay;
  } mail_result_t;

  // Mailbox state mirror and queue of pending result words.
  class mailbox_scoreboard;
    bit           used[PROCS*SLOTS];
    logic [3:0]   held_src[PROCS*SLOTS];
    logic [31:0]  held_pay[PROCS*SLOTS];
    int           age[PROCS*SLOTS];
    int           fill[PROCS];
    mail_result_t expected_results[$];
    int           fails;

    function int pending();
      return expected_results.size();
    endfunction

    function void note_word(logic op, logic [3:0] pid, logic [3:0] sid, logic any,
                            logic [31:0] pay);
      mail_result_t r;
      int base;
      int best;
      int rk;
      base = int'(pid) * SLOTS;
      best = -1;
      r.sts = STS_STORED;
      r.src = '0;
      r.pay = '0;
      if (op == OP_SEND) begin
        if (fill[pid] >= SLOTS) begin
          r.sts = STS_FULL;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (best < 0 && !used[base+i]) best = base + i;
          end
          used[best] = 1'b1;
          held_src[best] = sid;
          held_pay[best] = pay;
          age[best] = fill[pid];
          fill[pid]++;
        end
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (used[base+i] && (any || held_src[base+i] == sid)) begin
            if (best < 0 || age[base+i] < age[best]) best = base + i;
          end
        end
        if (best < 0) begin
          r.sts = STS_NO_MATCH;
        end else begin
          r.sts = STS_DELIVERED;
          r.src = held_src[best];
          r.pay = held_pay[best];
          rk = age[best];
          used[best] = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (used[base+i] && age[base+i] > rk) age[base+i]--;
          end
          fill[pid]--;
        end
      end
      expected_results.push_back(r);
    endfunction

    function void check_word(logic [1:0] sts, logic [39:0] data);
      mail_result_t e;
      if (expected_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result word: status %0d source %0d payload %h",
                   sts, data[3:0], data[35:4]);
        return;
      end
      e = expected_results.pop_front();
      if (sts !== e.sts || data[3:0] !== e.src || data[35:4] !== e.pay ||
          data[39:36] !== 4'd0) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected status %0d source %0d payload %h, got %0d %0d %h pad %h",
                   e.sts, e.src, e.pay, sts, data[3:0], data[35:4], data[39:36]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;

  mailbox_scoreboard sb = new();

  source_matching_mailbox_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall, one long hold-off on request.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tuser, out_tdata);
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer_word(input logic op, input logic [3:0] pid, input logic [3:0] sid,
                            input logic any, input logic [31:0] pay);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {7'd0, pay, any, sid, pid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(op, pid, sid, any, pay);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_set[4];
    int stall_set[4];
    logic [3:0] hot[3];
    logic op;
    int send_pct;
    logic [3:0] srcs[8];
    idle_set = '{0, 84, 0, 30};
    stall_set = '{0, 0, 84, 30};
    srcs = '{4'd1, 4'd2, 4'd1, 4'd3, 4'd2, 4'd1, 4'd4, 4'd7};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty mailbox, extremes, fill to full, source match, no match
    offer_word(OP_RECV, 4'd0, 4'd0, 1'b1, 32'h0);
    offer_word(OP_SEND, 4'd0, 4'd0, 1'b0, 32'h0);
    offer_word(OP_SEND, 4'd15, 4'd15, 1'b1, 32'hffff_ffff);
    offer_word(OP_RECV, 4'd15, 4'd15, 1'b0, 32'hffff_ffff);
    for (int i = 0; i < SLOTS; i++)
      offer_word(OP_SEND, 4'd5, srcs[i], 1'b0, 32'h1000_0000 + i);
    offer_word(OP_SEND, 4'd5, 4'd9, 1'b0, 32'hdead_beef);
    offer_word(OP_RECV, 4'd5, 4'd2, 1'b0, 32'h0);
    offer_word(OP_RECV, 4'd5, 4'd9, 1'b0, 32'h0);
    offer_word(OP_RECV, 4'd5, 4'd0, 1'b1, 32'h0);
    offer_word(OP_SEND, 4'd5, 4'd9, 1'b0, 32'h5555_aaaa);
    offer_word(OP_RECV, 4'd5, 4'd9, 1'b0, 32'h0);
    offer_word(OP_RECV, 4'd0, 4'd5, 1'b0, 32'h0);
    offer_word(OP_RECV, 4'd0, 4'd0, 1'b0, 32'h0);
    offer_word(OP_RECV, 4'd0, 4'd0, 1'b1, 32'h0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0) hold_req <= 1'b1;
      for (int k = 0; k < 3; k++) hot[k] = 4'($urandom);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        send_pct = ((n / 40) % 2) ? 35 : 70;
        op = ($urandom_range(99) < send_pct) ? OP_SEND : OP_RECV;
        offer_word(op,
                   ($urandom_range(99) < 75) ? hot[$urandom_range(2)] : 4'($urandom),
                   ($urandom_range(99) < 65) ? 4'($urandom_range(3)) : 4'($urandom),
                   1'($urandom_range(99) < 30),
                   $urandom);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/smm_pkg.sv
hw/rtl/smm_ram.sv
hw/rtl/smm_datapath.sv
hw/rtl/smm_ctrl.sv
hw/rtl/source_matching_mailbox_top.sv
hw/rtl/smm_checker.sv
test/tb_top.sv
